// ----- sv/hme_pkg.sv -----
// hme_pkg: shared types, constants and MD5 round tables for the HMAC-MD5 engine.
// No dependencies.
`default_nettype none
package hme_pkg;

	localparam int PAD_BYTES = 64;
	localparam int WORDS     = PAD_BYTES / 4;
	localparam int AW        = $clog2(WORDS);
	localparam int CW        = $clog2(PAD_BYTES) + 1;

	localparam logic [7:0] PAD_INNER = 8'h36;
	localparam logic [7:0] PAD_OUTER = 8'h5c;
	localparam logic [7:0] MARK_BYTE = 8'h80;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] chain_t;

	typedef enum logic [1:0] {
		CMD_KEY_BYTE = 2'd0,
		CMD_MSG_BYTE = 2'd1,
		CMD_END_KEY  = 2'd2,
		CMD_END_MSG  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_KEY,
		PH_LONGKEY,
		PH_MSG
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT,
		S_FIN,
		S_KWR,
		S_IWR,
		S_OPASS,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic init;
	} md5_cmd_t;

	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_idx;
		logic          done;
	} md5_sts_t;

	function automatic logic [31:0] md5_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] r);
		logic [3:0] rr;
		logic [3:0] g;
		rr = r[3:0];
		case (r[5:4])
			2'd0: g = rr;
			2'd1: g = rr + {rr[1:0], 2'b00} + 4'd1;
			2'd2: g = rr + {rr[2:0], 1'b0} + 4'd5;
			default: g = {rr[0], 3'b000} - rr;
		endcase
		return g;
	endfunction

	function automatic word_t md5_f(input logic [1:0] sel, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		case (sel)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage
`default_nettype wire

// ----- sv/hme_mem.sv -----
// hme_mem: word-wide synchronous RAM with byte lane enables, registered read.
// Depends on hme_pkg.
`default_nettype none
module hme_mem (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [hme_pkg::AW-1:0] waddr,
	input  wire logic [3:0]           be,
	input  wire hme_pkg::word_t       wdata,
	input  wire logic [hme_pkg::AW-1:0] raddr,
	output hme_pkg::word_t            rdata
);
	import hme_pkg::*;

	word_t mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int k = 0; k < 4; k++) begin
				if (be[k]) begin
					mem_q[waddr][8*k +: 8] <= wdata[8*k +: 8];
				end
			end
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/hme_md5.sv -----
// hme_md5: iterative MD5 compression, one round per cycle, message words fetched
// from an external RAM in the cycle before their round. Depends on hme_pkg.
`default_nettype none
module hme_md5 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hme_pkg::md5_cmd_t cmd,
	input  wire hme_pkg::word_t    word,
	output hme_pkg::md5_sts_t      sts,
	output hme_pkg::chain_t        chain
);
	import hme_pkg::*;

	logic       run_q;
	logic [5:0] iss_q;
	logic       v_s1;
	logic [5:0] rnd_s1;
	logic       add_q;
	logic       done_q;
	word_t      a_q, b_q, c_q, d_q;
	chain_t     chain_q;
	word_t      sum, nb;

	always_comb begin
		sum = a_q + md5_f(rnd_s1[5:4], b_q, c_q, d_q) + md5_k(rnd_s1) + word;
		nb  = b_q + rotl(sum, md5_s(rnd_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			iss_q  <= '0;
			v_s1   <= 1'b0;
			rnd_s1 <= '0;
			add_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				run_q <= 1'b1;
				iss_q <= '0;
			end else if (run_q) begin
				iss_q <= iss_q + 6'd1;
				if (iss_q == 6'd63) begin
					run_q <= 1'b0;
				end
			end
			v_s1   <= run_q;
			rnd_s1 <= iss_q;
			add_q  <= v_s1 && (rnd_s1 == 6'd63);
			done_q <= add_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.init) begin
				chain_q <= {IV3, IV2, IV1, IV0};
				a_q <= IV0; b_q <= IV1; c_q <= IV2; d_q <= IV3;
			end else begin
				a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
			end
		end else if (v_s1) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= nb;
		end
		if (add_q) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	assign sts.rd_en  = run_q;
	assign sts.rd_idx = md5_g(iss_q);
	assign sts.done   = done_q;
	assign chain      = chain_q;

endmodule
`default_nettype wire

// ----- sv/hmac_md5_engine_top.sv -----
// hmac_md5_engine_top: HMAC-MD5 sequencer around key/block RAMs and the MD5 core.
// Depends on hme_pkg, hme_mem, hme_md5.
//
//   channel | ports                          | beat
//   in      | in_valid in_ready cmd data_byte | one command / byte
//   out     | out_valid out_ready digest_byte is_last | one digest byte
//
// Key and message bytes are only written to RAM, except a byte that closes a
// 64-byte block, or the 65th key byte, which hashes the full key RAM: that beat
// also runs a block of MD5 rounds (one round per cycle, words read from RAM
// ahead of their round). End of key takes one block, or two to three blocks
// plus four RAM writes for a key over 64 bytes. End of message runs three to
// four blocks plus four RAM writes, then 16 output beats. Input stalls while
// the core runs; output stalls hold the byte. Reset gives key loading at once.
`default_nettype none
module hmac_md5_engine_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      digest_byte,
	output logic            is_last
);
	import hme_pkg::*;

	state_t         state_q, ns, nxt_q;
	phase_t         phase_q;
	logic [CW-1:0]  key_count_q;
	logic [63:0]    total_q;
	logic [1:0]     wcnt_q;
	logic [3:0]     ocnt_q;
	logic           two_q;
	logic           src_key_q, mark_en_q, len_en_q;
	logic [7:0]     pad_q;
	logic [CW-1:0]  lim_q;
	logic [CW-2:0]  mark_q;
	logic [AW-1:0]  widx_s1;

	logic           acc;
	logic           key_full;
	logic [CW-2:0]  fin_pos;
	logic           fin_two;
	logic           do_fin;
	logic           st, st_init, c_src_key, c_mark_en, c_len;
	logic [7:0]     c_pad;
	logic [CW-1:0]  c_lim;
	logic           kwe, bwe;
	logic [AW-1:0]  kaddr, baddr;
	logic [3:0]     kbe, bbe;
	word_t          kwdata, bwdata, krd, brd, rdat, word;
	logic [63:0]    bits;
	md5_cmd_t       mcmd;
	md5_sts_t       msts;
	chain_t         chain;

	assign acc      = in_valid && in_ready;
	assign key_full = key_count_q[CW-1];
	assign fin_pos  = total_q[CW-2:0];
	assign fin_two  = fin_pos[CW-2:CW-4] == 3'b111;
	assign bits     = {total_q[60:0], 3'b000};

	always_comb begin
		ns = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (phase_q)
						PH_KEY: begin
							if ((cmd == CMD_KEY_BYTE && key_full) || cmd == CMD_END_KEY) begin
								ns = S_WAIT;
							end
						end
						PH_LONGKEY: begin
							if (cmd == CMD_KEY_BYTE && fin_pos == '1) begin
								ns = S_WAIT;
							end else if (cmd == CMD_END_KEY) begin
								ns = S_FIN;
							end
						end
						PH_MSG: begin
							if (cmd == CMD_MSG_BYTE && fin_pos == '1) begin
								ns = S_WAIT;
							end else if (cmd == CMD_END_MSG) begin
								ns = S_FIN;
							end
						end
						default: ns = S_IDLE;
					endcase
				end
			end
			S_WAIT:  if (msts.done) ns = S_IDLE;
			S_FIN:   if (msts.done && !two_q) ns = nxt_q;
			S_KWR:   if (wcnt_q == 2'd3) ns = S_WAIT;
			S_IWR:   if (wcnt_q == 2'd3) ns = S_OPASS;
			S_OPASS: if (msts.done) ns = S_FIN;
			S_OUT:   if (out_ready && ocnt_q == 4'd15) ns = S_IDLE;
			default: ns = S_IDLE;
		endcase
	end

	always_comb begin
		st = 1'b0; st_init = 1'b0; do_fin = 1'b0;
		c_src_key = 1'b0; c_pad = 8'h00; c_lim = CW'(PAD_BYTES);
		c_mark_en = 1'b0; c_len = 1'b0;
		kwe = 1'b0; kaddr = key_count_q[CW-2:2]; kbe = 4'b0001 << key_count_q[1:0];
		kwdata = {4{data_byte}};
		bwe = 1'b0; baddr = total_q[CW-2:2]; bbe = 4'b0001 << total_q[1:0];
		bwdata = {4{data_byte}};
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (phase_q)
						PH_KEY: begin
							if (cmd == CMD_KEY_BYTE) begin
								if (!key_full) begin
									kwe = 1'b1;
								end else begin
									bwe = 1'b1;
									st = 1'b1; st_init = 1'b1; c_src_key = 1'b1;
								end
							end else if (cmd == CMD_END_KEY) begin
								st = 1'b1; st_init = 1'b1; c_src_key = 1'b1;
								c_pad = PAD_INNER; c_lim = key_count_q;
							end
						end
						PH_LONGKEY: begin
							if (cmd == CMD_KEY_BYTE) begin
								bwe = 1'b1;
								st  = fin_pos == '1;
							end else if (cmd == CMD_END_KEY) begin
								do_fin = 1'b1;
							end
						end
						PH_MSG: begin
							if (cmd == CMD_MSG_BYTE) begin
								bwe = 1'b1;
								st  = fin_pos == '1;
							end else if (cmd == CMD_END_MSG) begin
								do_fin = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_FIN: begin
				if (msts.done && two_q) begin
					st = 1'b1; c_lim = '0; c_len = 1'b1;
				end
			end
			S_KWR: begin
				kwe = 1'b1; kaddr = AW'(wcnt_q); kbe = 4'hf; kwdata = chain[wcnt_q];
				if (wcnt_q == 2'd3) begin
					st = 1'b1; st_init = 1'b1; c_src_key = 1'b1;
					c_pad = PAD_INNER; c_lim = CW'(16);
				end
			end
			S_IWR: begin
				bwe = 1'b1; baddr = AW'(wcnt_q); bbe = 4'hf; bwdata = chain[wcnt_q];
				if (wcnt_q == 2'd3) begin
					st = 1'b1; st_init = 1'b1; c_src_key = 1'b1;
					c_pad = PAD_OUTER; c_lim = key_count_q;
				end
			end
			S_OPASS: do_fin = msts.done;
			default: ;
		endcase
		if (do_fin) begin
			st = 1'b1; c_lim = {1'b0, fin_pos}; c_mark_en = 1'b1; c_len = !fin_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			phase_q     <= PH_KEY;
			key_count_q <= '0;
			total_q     <= '0;
			wcnt_q      <= '0;
			ocnt_q      <= '0;
			two_q       <= 1'b0;
		end else begin
			state_q <= ns;
			if (state_q == S_IDLE && acc) begin
				case (phase_q)
					PH_KEY: begin
						if (cmd == CMD_KEY_BYTE) begin
							if (!key_full) begin
								key_count_q <= key_count_q + 1'b1;
							end else begin
								total_q <= 64'd65;
								phase_q <= PH_LONGKEY;
							end
						end else if (cmd == CMD_END_KEY) begin
							total_q <= 64'(PAD_BYTES);
							phase_q <= PH_MSG;
						end
					end
					PH_LONGKEY: begin
						if (cmd == CMD_KEY_BYTE) total_q <= total_q + 64'd1;
						else if (cmd == CMD_END_KEY) nxt_q <= S_KWR;
					end
					PH_MSG: begin
						if (cmd == CMD_MSG_BYTE) total_q <= total_q + 64'd1;
						else if (cmd == CMD_END_MSG) nxt_q <= S_IWR;
					end
					default: ;
				endcase
			end
			if (state_q == S_OPASS) nxt_q <= S_OUT;
			if (do_fin) begin
				two_q <= fin_two;
			end else if (state_q == S_FIN && msts.done) begin
				two_q <= 1'b0;
			end
			if (state_q == S_KWR || state_q == S_IWR) begin
				wcnt_q <= wcnt_q + 2'd1;
			end
			if (state_q == S_KWR && wcnt_q == 2'd3) begin
				key_count_q <= CW'(16);
				total_q     <= 64'(PAD_BYTES);
				phase_q     <= PH_MSG;
			end
			if (state_q == S_IWR && wcnt_q == 2'd3) begin
				total_q <= 64'(PAD_BYTES + 16);
			end
			if (state_q == S_OUT && out_ready) begin
				ocnt_q <= ocnt_q + 4'd1;
				if (ocnt_q == 4'd15) begin
					key_count_q <= '0;
					total_q     <= '0;
					phase_q     <= PH_KEY;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st) begin
			src_key_q <= c_src_key;
			pad_q     <= c_pad;
			lim_q     <= c_lim;
			mark_en_q <= c_mark_en;
			mark_q    <= fin_pos;
			len_en_q  <= c_len;
		end
		widx_s1 <= msts.rd_idx;
	end

	// message word: RAM bytes below the limit, end mark, pad XOR, length words
	always_comb begin
		logic [CW-2:0] p;
		logic [7:0]    bv;
		rdat = src_key_q ? krd : brd;
		for (int k = 0; k < 4; k++) begin
			p  = {widx_s1, 2'(k)};
			bv = ({1'b0, p} < lim_q) ? rdat[8*k +: 8] : 8'h00;
			if (mark_en_q && p == mark_q) bv = MARK_BYTE;
			word[8*k +: 8] = bv ^ pad_q;
		end
		if (len_en_q && widx_s1 == AW'(WORDS - 2)) word = bits[31:0];
		if (len_en_q && widx_s1 == AW'(WORDS - 1)) word = bits[63:32];
	end

	assign mcmd.start = st;
	assign mcmd.init  = st_init;

	hme_mem u_key_mem (
		.clk(clk), .we(kwe), .waddr(kaddr), .be(kbe), .wdata(kwdata),
		.raddr(msts.rd_idx), .rdata(krd)
	);

	hme_mem u_blk_mem (
		.clk(clk), .we(bwe), .waddr(baddr), .be(bbe), .wdata(bwdata),
		.raddr(msts.rd_idx), .rdata(brd)
	);

	hme_md5 u_md5 (
		.clk(clk), .arst_n(arst_n), .cmd(mcmd), .word(word), .sts(msts), .chain(chain)
	);

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = state_q == S_OUT;
	assign digest_byte = chain[ocnt_q[3:2]][8*ocnt_q[1:0] +: 8];
	assign is_last     = ocnt_q == 4'd15;

endmodule
`default_nettype wire
